### rtl/core/bmpd_pkg.sv
// Shared types and constants of the BMP stream decoder.
`timescale 1ns / 1ps

package bmpd_pkg;

   // header layout (byte offsets from the start of the file)
   localparam int unsigned HDR_LAST   = 53;
   localparam int unsigned OFS_SIG0   = 0;
   localparam int unsigned OFS_SIG1   = 1;
   localparam int unsigned OFS_DATA   = 10;
   localparam int unsigned OFS_INFO   = 14;
   localparam int unsigned OFS_WIDTH  = 18;
   localparam int unsigned OFS_HEIGHT = 22;
   localparam int unsigned OFS_PLANES = 26;
   localparam int unsigned OFS_BPP    = 28;
   localparam int unsigned OFS_COMP   = 30;

   localparam logic [7:0]  SIG_B      = 8'h42;
   localparam logic [7:0]  SIG_M      = 8'h4D;
   localparam logic [31:0] MIN_INFO   = 32'd40;
   localparam logic [15:0] ONE_PLANE  = 16'd1;
   localparam logic [15:0] BPP_24     = 16'd24;
   localparam logic [15:0] BPP_32     = 16'd32;
   localparam logic [31:0] NO_COMP    = 32'd0;
   localparam logic [31:0] MIN_OFFSET = 32'd54;

   localparam int unsigned RSP_DATA_W = 72;

   typedef enum logic [1:0] {
      ST_PIXEL  = 2'd0,
      ST_ACCEPT = 2'd1,
      ST_REJECT = 2'd2,
      ST_TRUNC  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_SKIP   = 4'b0010,
      PH_PIXELS = 4'b0100,
      PH_IDLE   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0]  sig0;
      logic [7:0]  sig1;
      logic [31:0] data_offset;
      logic [31:0] info_size;
      logic [15:0] planes;
      logic [15:0] bpp;
      logic [31:0] width;
      logic [31:0] height;
      logic [31:0] compression;
   } hdr_fields_type;

   typedef struct packed {
      logic ok;
      logic top_first;
      logic four_byte;
   } hdr_verdict_type;

   typedef struct packed {
      status_type  status;
      logic [23:0] pixel_word;
      logic [10:0] pixel_column;
      logic [10:0] pixel_row;
      logic [11:0] image_width;
      logic [11:0] image_height;
      logic        image_done;
   } rsp_type;

endpackage

### rtl/core/bmpd_hdr_check.sv
// Header validity check and image geometry extraction.
`timescale 1ns / 1ps

module bmpd_hdr_check #(
   parameter int unsigned MAX_DIMENSION = 2048,
   parameter int unsigned DIM_W         = 12
) (
   input  bmpd_pkg::hdr_fields_type  fields,
   output bmpd_pkg::hdr_verdict_type verdict,
   output logic [DIM_W-1:0]          width_out,
   output logic [DIM_W-1:0]          height_out
);

   logic        down;
   logic [31:0] mag;

   always_comb begin
      down = fields.height[31];
      // a height of INT_MIN negates to itself and fails the range check
      mag  = down ? (32'd0 - fields.height) : fields.height;

      verdict.top_first = down;
      verdict.four_byte = (fields.bpp == bmpd_pkg::BPP_32);
      verdict.ok = (fields.sig0 == bmpd_pkg::SIG_B) && (fields.sig1 == bmpd_pkg::SIG_M)
                && (fields.info_size >= bmpd_pkg::MIN_INFO)
                && (fields.planes == bmpd_pkg::ONE_PLANE)
                && ((fields.bpp == bmpd_pkg::BPP_24) || (fields.bpp == bmpd_pkg::BPP_32))
                && (fields.compression == bmpd_pkg::NO_COMP)
                && (fields.width != 32'd0) && (fields.width <= 32'(MAX_DIMENSION))
                && (mag != 32'd0) && (mag <= 32'(MAX_DIMENSION))
                && (fields.data_offset >= bmpd_pkg::MIN_OFFSET);

      width_out  = fields.width[DIM_W-1:0];
      height_out = mag[DIM_W-1:0];
   end

endmodule

### rtl/core/bmpd_rsp_buf.sv
// Result register with a skid stage behind it.
`timescale 1ns / 1ps

module bmpd_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  bmpd_pkg::rsp_type push_data,
   output logic              push_ready,
   output logic              pop_valid,
   input  logic              pop_ready,
   output bmpd_pkg::rsp_type pop_data
);

   logic              out_valid_ff,  out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   bmpd_pkg::rsp_type out_data_ff,   out_data_in;
   bmpd_pkg::rsp_type skid_data_ff,  skid_data_in;
   logic              out_free;

   assign push_ready = !skid_valid_ff;
   assign pop_valid  = out_valid_ff;
   assign pop_data   = out_data_ff;

   always_comb begin
      out_free      = !out_valid_ff || pop_ready;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // drain the skid first to keep order
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push_valid;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push_valid;
            out_data_in  = push_data;
         end
      end else if (push_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

### rtl/core/bmp_stream_decoder.sv
// Top level of the streaming BMP decoder for uncompressed 24 and 32 bpp files.
`timescale 1ns / 1ps

// Takes one file byte per beat and sustains one byte per cycle; each byte is
// handled in the cycle it is accepted; its result, if any, is pushed into
// the result register or its skid stage. The only stall source is the result
// side: req_tready drops when both the result register and its skid stage
// are full. Raising req_tuser on a byte restarts parsing with that byte as
// file offset zero. Results: status 1 with the image size once the 54-byte
// header passes, status 2 if it fails, one status 0 beat per pixel in file
// order (rsp_tlast on the final pixel), and status 3 if the file ends early,
// after which everything received for that file should be discarded.

module bmp_stream_decoder #(
   parameter int unsigned MAX_DIMENSION = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] file_byte
   input  logic [0:0]  req_tuser,   // [0] first_of_file
   input  logic        req_tlast,   // last_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [23:0] pixel_word, [34:24] pixel_column, [45:35] pixel_row,
   // [57:46] image_width, [69:58] image_height, [71:70] zero
   output logic [bmpd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // image_done
);

   localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);

   bmpd_pkg::phase_type       phase_ff,      phase_in,  phase_cur;
   logic [31:0]               offset_ff,     offset_in, here;
   bmpd_pkg::hdr_fields_type  fields_ff,     fields_in;
   logic [31:0]               data_start_ff, data_start_in;
   logic [DIM_W-1:0]          width_ff,      width_in;
   logic [DIM_W-1:0]          height_ff,     height_in;
   logic                      top_first_ff,  top_first_in;
   logic                      four_ff,       four_in;
   logic [DIM_W-1:0]          col_ff,        col_in;
   logic [DIM_W-1:0]          row_ff,        row_in;
   logic [1:0]                sub_ff,        sub_in;
   logic [1:0]                pad_ff,        pad_in;
   logic [7:0]                byte0_ff,      byte0_in;
   logic [7:0]                byte1_ff,      byte1_in;

   bmpd_pkg::hdr_verdict_type verdict;
   logic [DIM_W-1:0]          chk_width, chk_height;

   logic                      accept, first, last;
   logic [7:0]                b;
   logic [1:0]                lane4;
   logic                      pix_go, stop, sub_last, final_px;
   logic [DIM_W-1:0]          col_inc, row_inc, dest;
   logic [1:0]                pad_amt;
   logic                      push_valid, push_ready;
   bmpd_pkg::rsp_type         rsp, pop_data;

   bmpd_hdr_check #(
      .MAX_DIMENSION(MAX_DIMENSION),
      .DIM_W        (DIM_W)
   ) u_hdr_check (
      .fields    (fields_ff),
      .verdict   (verdict),
      .width_out (chk_width),
      .height_out(chk_height)
   );

   assign accept = req_tvalid && req_tready;
   assign first  = req_tuser[0];
   assign last   = req_tlast;
   assign b      = req_tdata;

   always_comb begin
      phase_cur     = first ? bmpd_pkg::PH_HEADER : phase_ff;
      here          = first ? 32'd0 : offset_ff;
      lane4         = here[1:0] + 2'd2;

      phase_in      = phase_ff;
      offset_in     = offset_ff;
      fields_in     = fields_ff;
      data_start_in = data_start_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      top_first_in  = top_first_ff;
      four_in       = four_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      sub_in        = sub_ff;
      pad_in        = pad_ff;
      byte0_in      = byte0_ff;
      byte1_in      = byte1_ff;
      push_valid    = 1'b0;
      rsp           = '0;
      pix_go        = 1'b0;
      stop          = 1'b0;

      sub_last = (sub_ff == (four_ff ? 2'd3 : 2'd2));
      col_inc  = col_ff + DIM_W'(1);
      row_inc  = row_ff + DIM_W'(1);
      final_px = (row_inc == height_ff) && (col_inc == width_ff);
      dest     = top_first_ff ? row_ff : (height_ff - DIM_W'(1) - row_ff);
      pad_amt  = four_ff ? 2'd0 : 2'(width_ff);

      if (accept) begin
         phase_in  = phase_cur;
         // saturate the offset counter
         offset_in = (here == 32'hFFFF_FFFF) ? here : here + 32'd1;

         unique case (phase_cur)
            bmpd_pkg::PH_HEADER: begin
               if (here == 32'(bmpd_pkg::OFS_SIG0)) fields_in.sig0 = b;
               if (here == 32'(bmpd_pkg::OFS_SIG1)) fields_in.sig1 = b;
               if (here >= 32'(bmpd_pkg::OFS_DATA) && here < 32'(bmpd_pkg::OFS_DATA + 4))
                  fields_in.data_offset[{lane4, 3'b000} +: 8] = b;
               if (here >= 32'(bmpd_pkg::OFS_INFO) && here < 32'(bmpd_pkg::OFS_INFO + 4))
                  fields_in.info_size[{lane4, 3'b000} +: 8] = b;
               if (here >= 32'(bmpd_pkg::OFS_WIDTH) && here < 32'(bmpd_pkg::OFS_WIDTH + 4))
                  fields_in.width[{lane4, 3'b000} +: 8] = b;
               if (here >= 32'(bmpd_pkg::OFS_HEIGHT) && here < 32'(bmpd_pkg::OFS_HEIGHT + 4))
                  fields_in.height[{lane4, 3'b000} +: 8] = b;
               if (here >= 32'(bmpd_pkg::OFS_PLANES) && here < 32'(bmpd_pkg::OFS_PLANES + 2))
                  fields_in.planes[{here[0], 3'b000} +: 8] = b;
               if (here >= 32'(bmpd_pkg::OFS_BPP) && here < 32'(bmpd_pkg::OFS_BPP + 2))
                  fields_in.bpp[{here[0], 3'b000} +: 8] = b;
               if (here >= 32'(bmpd_pkg::OFS_COMP) && here < 32'(bmpd_pkg::OFS_COMP + 4))
                  fields_in.compression[{lane4, 3'b000} +: 8] = b;

               // every checked field lies well before the last header byte
               if (here == 32'(bmpd_pkg::HDR_LAST)) begin
                  push_valid = 1'b1;
                  if (!verdict.ok) begin
                     phase_in   = bmpd_pkg::PH_IDLE;
                     rsp.status = bmpd_pkg::ST_REJECT;
                  end else begin
                     data_start_in = fields_ff.data_offset;
                     width_in      = chk_width;
                     height_in     = chk_height;
                     top_first_in  = verdict.top_first;
                     four_in       = verdict.four_byte;
                     col_in        = '0;
                     row_in        = '0;
                     sub_in        = '0;
                     pad_in        = '0;
                     if (last) begin
                        phase_in   = bmpd_pkg::PH_IDLE;
                        rsp.status = bmpd_pkg::ST_TRUNC;
                     end else begin
                        phase_in          = bmpd_pkg::PH_SKIP;
                        rsp.status        = bmpd_pkg::ST_ACCEPT;
                        rsp.image_width   = 12'(chk_width);
                        rsp.image_height  = 12'(chk_height);
                     end
                  end
               end else if (last) begin
                  phase_in   = bmpd_pkg::PH_IDLE;
                  push_valid = 1'b1;
                  rsp.status = bmpd_pkg::ST_TRUNC;
               end
            end
            bmpd_pkg::PH_SKIP: begin
               if (here == data_start_ff) begin
                  phase_in = bmpd_pkg::PH_PIXELS;
                  pix_go   = 1'b1;
               end else if (last) begin
                  phase_in   = bmpd_pkg::PH_IDLE;
                  push_valid = 1'b1;
                  rsp.status = bmpd_pkg::ST_TRUNC;
               end
            end
            bmpd_pkg::PH_PIXELS: begin
               pix_go = 1'b1;
            end
            bmpd_pkg::PH_IDLE: begin
               // hold until the next file starts
            end
            default: begin
               phase_in = bmpd_pkg::PH_IDLE;
            end
         endcase
      end

      if (pix_go) begin
         if (pad_ff == 2'd0) begin
            if (sub_ff == 2'd0) byte0_in = b;
            if (sub_ff == 2'd1) byte1_in = b;
            // a pixel completes on its red byte
            if (sub_ff == 2'd2) begin
               push_valid = 1'b1;
               if (last && !final_px) begin
                  stop       = 1'b1;
                  phase_in   = bmpd_pkg::PH_IDLE;
                  rsp.status = bmpd_pkg::ST_TRUNC;
               end else begin
                  rsp.status       = bmpd_pkg::ST_PIXEL;
                  rsp.pixel_word   = {b, byte1_ff, byte0_ff};
                  rsp.pixel_column = 11'(col_ff);
                  rsp.pixel_row    = 11'(dest);
                  rsp.image_width  = 12'(width_ff);
                  rsp.image_height = 12'(height_ff);
                  rsp.image_done   = final_px;
                  if (final_px) begin
                     stop     = 1'b1;
                     phase_in = bmpd_pkg::PH_IDLE;
                  end
               end
            end
         end

         if (!stop) begin
            if (pad_ff == 2'd0) begin
               if (sub_last) begin
                  sub_in = 2'd0;
                  if (col_inc == width_ff) begin
                     col_in = '0;
                     if (pad_amt == 2'd0) row_in = row_inc;
                     else                 pad_in = pad_amt;
                  end else begin
                     col_in = col_inc;
                  end
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
            end else begin
               // row padding up to a four-byte boundary
               pad_in = pad_ff - 2'd1;
               if (pad_ff == 2'd1) row_in = row_inc;
            end
            if (!push_valid && last) begin
               phase_in   = bmpd_pkg::PH_IDLE;
               push_valid = 1'b1;
               rsp.status = bmpd_pkg::ST_TRUNC;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= bmpd_pkg::PH_HEADER;
         offset_ff     <= '0;
         data_start_ff <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         top_first_ff  <= 1'b0;
         four_ff       <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         sub_ff        <= '0;
         pad_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         offset_ff     <= offset_in;
         data_start_ff <= data_start_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         top_first_ff  <= top_first_in;
         four_ff       <= four_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         sub_ff        <= sub_in;
         pad_ff        <= pad_in;
      end
      fields_ff <= fields_in;
      byte0_ff  <= byte0_in;
      byte1_ff  <= byte1_in;
   end

   bmpd_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_data (rsp),
      .push_ready(push_ready),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_data  (pop_data)
   );

   assign req_tready = push_ready;
   assign rsp_tdata  = {2'b00, pop_data.image_height, pop_data.image_width,
                        pop_data.pixel_row, pop_data.pixel_column, pop_data.pixel_word};
   assign rsp_tuser  = pop_data.status;
   assign rsp_tlast  = pop_data.image_done;

endmodule

### dv/tb_top.sv
// Self-checking bench for the BMP stream decoder: byte beats in, result beats checked.
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned MAX_DIM      = 2048;
   localparam int unsigned IDLE_PCT     = 13;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned RANDOM_BYTES = 500;
   localparam longint unsigned LIMIT_NS = 6_000_000;

   // ways a header can fail the check
   typedef enum {
      FLAW_SIG0,
      FLAW_SIG1,
      FLAW_INFO,
      FLAW_PLANES,
      FLAW_BPP,
      FLAW_COMP,
      FLAW_WIDTH_ZERO,
      FLAW_WIDTH_BIG,
      FLAW_HEIGHT_ZERO,
      FLAW_HEIGHT_BIG,
      FLAW_HEIGHT_MIN,
      FLAW_OFFSET
   } flaw_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;   // [7:0] file_byte
   logic [0:0] req_tuser  = '0;   // [0] first_of_file
   logic       req_tlast  = 1'b0; // last_of_file
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   // [23:0] pixel_word, [34:24] pixel_column, [45:35] pixel_row,
   // [57:46] image_width, [69:58] image_height, [71:70] zero
   logic [bmpd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;         // [1:0] status
   logic       rsp_tlast;         // image_done

   logic calm        = 1'b0;      // no idling on either side while set
   logic hold_active = 1'b0;
   event hold_start;

   int unsigned fail_count = 0;
   int unsigned rsp_seen   = 0;
   int unsigned sent_bytes = 0;

   bmpd_pkg::rsp_type expected_rsp[$];
   logic [7:0]        file_q[$];

   // decoder state as predicted
   bmpd_pkg::phase_type dec_phase = bmpd_pkg::PH_HEADER;
   logic [31:0] file_pos      = '0;
   logic [7:0]  hdr_bytes [0:bmpd_pkg::HDR_LAST];
   logic [31:0] pix_start     = '0;
   int unsigned img_w         = 0;
   int unsigned img_h         = 0;
   bit          img_top_first = 1'b0;
   bit          img_four_byte = 1'b0;
   int unsigned col_idx       = 0;
   int unsigned row_idx       = 0;
   int unsigned row_pos       = 0;
   logic [15:0] part_pixel    = '0;

   bmp_stream_decoder #(
      .MAX_DIMENSION(MAX_DIM)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] hdr_le(int unsigned at, int unsigned n);
      logic [31:0] v;
      v = '0;
      for (int i = 0; i < n; i++) v[8*i +: 8] = hdr_bytes[at + i];
      return v;
   endfunction

   // check the collected header; load the image registers when it passes
   function automatic bit header_ok();
      logic [31:0] offs, w, h, mag;
      logic [15:0] bpp;
      offs = hdr_le(bmpd_pkg::OFS_DATA, 4);
      w    = hdr_le(bmpd_pkg::OFS_WIDTH, 4);
      h    = hdr_le(bmpd_pkg::OFS_HEIGHT, 4);
      bpp  = 16'(hdr_le(bmpd_pkg::OFS_BPP, 2));
      mag  = h[31] ? 32'd0 - h : h;
      if (hdr_bytes[bmpd_pkg::OFS_SIG0] != bmpd_pkg::SIG_B) return 1'b0;
      if (hdr_bytes[bmpd_pkg::OFS_SIG1] != bmpd_pkg::SIG_M) return 1'b0;
      if (hdr_le(bmpd_pkg::OFS_INFO, 4) < bmpd_pkg::MIN_INFO) return 1'b0;
      if (16'(hdr_le(bmpd_pkg::OFS_PLANES, 2)) != bmpd_pkg::ONE_PLANE) return 1'b0;
      if (bpp != bmpd_pkg::BPP_24 && bpp != bmpd_pkg::BPP_32) return 1'b0;
      if (hdr_le(bmpd_pkg::OFS_COMP, 4) != bmpd_pkg::NO_COMP) return 1'b0;
      if (w == 0 || w > MAX_DIM) return 1'b0;
      if (mag == 0 || mag > MAX_DIM) return 1'b0;
      if (offs < bmpd_pkg::MIN_OFFSET) return 1'b0;
      pix_start     = offs;
      img_w         = w;
      img_h         = mag;
      img_top_first = h[31];
      img_four_byte = (bpp == bmpd_pkg::BPP_32);
      col_idx       = 0;
      row_idx       = 0;
      row_pos       = 0;
      part_pixel    = '0;
      return 1'b1;
   endfunction

   function automatic void push_status(bmpd_pkg::status_type st);
      bmpd_pkg::rsp_type r;
      r = '0;
      r.status = st;
      if (st == bmpd_pkg::ST_ACCEPT) begin
         r.image_width  = 12'(img_w);
         r.image_height = 12'(img_h);
      end
      expected_rsp.push_back(r);
   endfunction

   function automatic void take_pixel_byte(logic [7:0] b, bit last);
      int unsigned       bpp, span, stride, pos, sub, dest;
      bit                fin, emitted;
      bmpd_pkg::rsp_type r;
      bpp     = img_four_byte ? 4 : 3;
      span    = img_w * bpp;
      stride  = (span + 3) & 32'hFFFF_FFFC;
      pos     = row_pos;
      emitted = 1'b0;
      if (pos < span) begin
         sub = pos - col_idx * bpp;
         if (sub == 0) begin
            part_pixel = {8'h00, b};
         end else if (sub == 1) begin
            part_pixel = {b, part_pixel[7:0]};
         end else if (sub == 2) begin
            fin  = (row_idx + 1 == img_h) && (col_idx + 1 == img_w);
            dest = img_top_first ? row_idx : img_h - 1 - row_idx;
            if (last && !fin) begin
               dec_phase = bmpd_pkg::PH_IDLE;
               push_status(bmpd_pkg::ST_TRUNC);
               return;
            end
            r = '0;
            r.status       = bmpd_pkg::ST_PIXEL;
            r.pixel_word   = {b, part_pixel};
            r.pixel_column = 11'(col_idx);
            r.pixel_row    = 11'(dest);
            r.image_width  = 12'(img_w);
            r.image_height = 12'(img_h);
            r.image_done   = fin;
            expected_rsp.push_back(r);
            emitted = 1'b1;
            if (fin) begin
               dec_phase = bmpd_pkg::PH_IDLE;
               return;
            end
         end
         if (sub + 1 == bpp) col_idx++;
      end
      row_pos = pos + 1;
      if (row_pos >= stride) begin
         row_pos = 0;
         col_idx = 0;
         row_idx++;
      end
      if (!emitted && last) begin
         dec_phase = bmpd_pkg::PH_IDLE;
         push_status(bmpd_pkg::ST_TRUNC);
      end
   endfunction

   function automatic void decode_byte(logic [7:0] b, bit first, bit last);
      logic [31:0] here;
      if (first) begin
         dec_phase = bmpd_pkg::PH_HEADER;
         file_pos  = '0;
      end
      here = file_pos;
      if (file_pos != 32'hFFFF_FFFF) file_pos++;
      case (dec_phase)
         bmpd_pkg::PH_HEADER: begin
            if (here <= bmpd_pkg::HDR_LAST) hdr_bytes[here] = b;
            if (here >= bmpd_pkg::HDR_LAST) begin
               if (!header_ok()) begin
                  dec_phase = bmpd_pkg::PH_IDLE;
                  push_status(bmpd_pkg::ST_REJECT);
               end else if (last) begin
                  dec_phase = bmpd_pkg::PH_IDLE;
                  push_status(bmpd_pkg::ST_TRUNC);
               end else begin
                  dec_phase = bmpd_pkg::PH_SKIP;
                  push_status(bmpd_pkg::ST_ACCEPT);
               end
            end else if (last) begin
               dec_phase = bmpd_pkg::PH_IDLE;
               push_status(bmpd_pkg::ST_TRUNC);
            end
         end
         bmpd_pkg::PH_SKIP: begin
            if (here == pix_start) begin
               dec_phase = bmpd_pkg::PH_PIXELS;
               take_pixel_byte(b, last);
            end else if (last) begin
               dec_phase = bmpd_pkg::PH_IDLE;
               push_status(bmpd_pkg::ST_TRUNC);
            end
         end
         bmpd_pkg::PH_PIXELS: take_pixel_byte(b, last);
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- file building

   function automatic bmpd_pkg::hdr_fields_type good_fields(int unsigned w, int unsigned hmag,
                                                            bit top_first, bit four);
      bmpd_pkg::hdr_fields_type f;
      f.sig0        = bmpd_pkg::SIG_B;
      f.sig1        = bmpd_pkg::SIG_M;
      f.data_offset = ($urandom_range(0, 3) == 0)
                      ? bmpd_pkg::MIN_OFFSET + $urandom_range(1, 16)
                      : bmpd_pkg::MIN_OFFSET;
      case ($urandom_range(0, 3))
         0, 1:    f.info_size = bmpd_pkg::MIN_INFO;
         2:       f.info_size = bmpd_pkg::MIN_INFO + $urandom_range(1, 300);
         default: f.info_size = 32'hFFFF_FFFF;
      endcase
      f.planes      = bmpd_pkg::ONE_PLANE;
      f.bpp         = four ? bmpd_pkg::BPP_32 : bmpd_pkg::BPP_24;
      f.width       = w;
      f.height      = top_first ? 32'd0 - hmag : hmag;
      f.compression = bmpd_pkg::NO_COMP;
      return f;
   endfunction

   function automatic bmpd_pkg::hdr_fields_type flawed_fields(flaw_type k);
      bmpd_pkg::hdr_fields_type f;
      logic [31:0]              mag;
      f = good_fields($urandom_range(1, 6), $urandom_range(1, 4),
                      $urandom_range(0, 1), $urandom_range(0, 1));
      case (k)
         FLAW_SIG0:   f.sig0 = bmpd_pkg::SIG_B ^ 8'($urandom_range(1, 255));
         FLAW_SIG1:   f.sig1 = bmpd_pkg::SIG_M ^ 8'($urandom_range(1, 255));
         FLAW_INFO:   f.info_size = $urandom_range(0, bmpd_pkg::MIN_INFO - 1);
         FLAW_PLANES: f.planes = $urandom_range(0, 1)
                                 ? 16'd0
                                 : bmpd_pkg::ONE_PLANE + 16'($urandom_range(1, 65534));
         FLAW_BPP: begin
            f.bpp = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 40));
            if (f.bpp == bmpd_pkg::BPP_24 || f.bpp == bmpd_pkg::BPP_32)
               f.bpp = f.bpp + 16'd1;
         end
         FLAW_COMP:   f.compression = $urandom_range(0, 1) ? $urandom_range(1, 6)
                                                           : $urandom | 32'd1;
         FLAW_WIDTH_ZERO: f.width = '0;
         FLAW_WIDTH_BIG:  f.width = $urandom_range(0, 1) ? MAX_DIM + 1 : $urandom | 32'h0000_1000;
         FLAW_HEIGHT_ZERO: f.height = '0;
         FLAW_HEIGHT_BIG: begin
            mag = $urandom_range(0, 1) ? MAX_DIM + 1 : $urandom_range(MAX_DIM + 1, 32'h7FFF_FFFF);
            f.height = $urandom_range(0, 1) ? 32'd0 - mag : mag;
         end
         FLAW_HEIGHT_MIN: f.height = 32'h8000_0000;
         FLAW_OFFSET:     f.data_offset = $urandom_range(0, bmpd_pkg::MIN_OFFSET - 1);
         default: ;
      endcase
      return f;
   endfunction

   function automatic void put_le(int unsigned at, logic [31:0] v, int unsigned n);
      for (int i = 0; i < n; i++) file_q[at + i] = v[8*i +: 8];
   endfunction

   // header bytes not covered by the check are left random
   function automatic void build_header(bmpd_pkg::hdr_fields_type f);
      file_q.delete();
      repeat (bmpd_pkg::HDR_LAST + 1) file_q.push_back(8'($urandom));
      file_q[bmpd_pkg::OFS_SIG0] = f.sig0;
      file_q[bmpd_pkg::OFS_SIG1] = f.sig1;
      put_le(bmpd_pkg::OFS_DATA, f.data_offset, 4);
      put_le(bmpd_pkg::OFS_INFO, f.info_size, 4);
      put_le(bmpd_pkg::OFS_WIDTH, f.width, 4);
      put_le(bmpd_pkg::OFS_HEIGHT, f.height, 4);
      put_le(bmpd_pkg::OFS_PLANES, f.planes, 2);
      put_le(bmpd_pkg::OFS_BPP, f.bpp, 2);
      put_le(bmpd_pkg::OFS_COMP, f.compression, 4);
   endfunction

   // bytes up to and including the red byte of the final pixel
   function automatic int unsigned image_len(bmpd_pkg::hdr_fields_type f);
      int unsigned bpp, stride, mag;
      bpp    = (f.bpp == bmpd_pkg::BPP_32) ? 4 : 3;
      mag    = f.height[31] ? 32'd0 - f.height : f.height;
      stride = (f.width * bpp + 3) & 32'hFFFF_FFFC;
      return f.data_offset + (mag - 1) * stride + (f.width - 1) * bpp + 3;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_byte(logic [7:0] b, bit first, bit last);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      decode_byte(b, first, last);
   endtask

   // send file_q, extended with random bytes up to len; the first beat restarts parsing
   task automatic send_file(int unsigned len, bit mark_last, int unsigned counted_len);
      for (int unsigned i = 0; i < len; i++) begin
         send_byte((i < file_q.size()) ? file_q[i] : 8'($urandom), i == 0,
                   mark_last && (i == len - 1));
         if (i < counted_len) sent_bytes++;
      end
   endtask

   always @(posedge clock) begin
      if (hold_active) rsp_tready <= 1'b0;
      else if (calm)   rsp_tready <= 1'b1;
      else             rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // long hold-off of the result side, counted here
   always begin
      @(hold_start);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("beat %0d %s: got %0h, expected %0h",
                                   rsp_seen, name, got, want));
   endtask

   always @(posedge clock) begin
      bmpd_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with nothing expected", rsp_seen));
         end else begin
            want = expected_rsp.pop_front();
            check_field("status", rsp_tuser, want.status);
            check_field("pixel_word", rsp_tdata[23:0], want.pixel_word);
            check_field("pixel_column", rsp_tdata[34:24], want.pixel_column);
            check_field("pixel_row", rsp_tdata[45:35], want.pixel_row);
            check_field("image_width", rsp_tdata[57:46], want.image_width);
            check_field("image_height", rsp_tdata[69:58], want.image_height);
            check_field("padding", rsp_tdata[71:70], '0);
            check_field("image_done", rsp_tlast, want.image_done);
         end
         rsp_seen++;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_complete_images();
      bmpd_pkg::hdr_fields_type f;
      // 1x1 at 24 bpp, pixel data straight after the header
      f = good_fields(1, 1, 1'b0, 1'b0);
      f.data_offset = bmpd_pkg::MIN_OFFSET;
      build_header(f);
      send_file(image_len(f), 1'b1, 0);
      // 1x1 at 32 bpp top-down: the fourth byte never comes
      f = good_fields(1, 1, 1'b1, 1'b1);
      build_header(f);
      send_file(image_len(f), 1'b1, 0);
      // stray bytes after the final pixel are dropped
      f = good_fields(3, 2, 1'b0, 1'b0);
      build_header(f);
      send_file(image_len(f) + 4, 1'b1, 0);
   endtask

   task automatic test_header_rejects();
      bmpd_pkg::hdr_fields_type f;
      flaw_type                 fk;
      for (int k = 0; k < fk.num(); k++) begin
         fk = flaw_type'(k);
         f  = flawed_fields(fk);
         build_header(f);
         // one of them ends the file on its last header byte
         send_file(bmpd_pkg::HDR_LAST + 1, fk == FLAW_PLANES, 0);
      end
   endtask

   task automatic test_early_end();
      bmpd_pkg::hdr_fields_type f;
      f = good_fields(3, 2, 1'b0, 1'b0);
      f.data_offset = bmpd_pkg::MIN_OFFSET + 6;
      build_header(f);
      send_file(1, 1'b1, 0);                          // single-beat file
      send_file(bmpd_pkg::HDR_LAST + 1, 1'b1, 0);     // ends on an acceptable header
      send_file(bmpd_pkg::MIN_OFFSET + 3, 1'b1, 0);   // ends in the gap
      send_file(f.data_offset + 3, 1'b1, 0);          // ends on a non-final red byte
      send_file(f.data_offset + 2, 1'b1, 0);          // ends on a green byte
      f = good_fields(1, 2, 1'b1, 1'b0);
      build_header(f);
      send_file(f.data_offset + 4, 1'b1, 0);          // ends on row padding
      f = good_fields(2, 1, 1'b0, 1'b1);
      build_header(f);
      send_file(f.data_offset + 4, 1'b1, 0);          // ends on a non-final fourth byte
   endtask

   task automatic test_restart();
      bmpd_pkg::hdr_fields_type f;
      f = good_fields(4, 3, 1'b0, 1'b1);
      f.data_offset = bmpd_pkg::MIN_OFFSET + 12;
      build_header(f);
      send_file(20, 1'b0, 0);                          // cut inside the header
      send_file(bmpd_pkg::MIN_OFFSET + 5, 1'b0, 0);    // cut in the gap
      send_file(f.data_offset + 17, 1'b0, 0);          // cut among the pixels
      send_file(image_len(f), 1'b1, 0);
   endtask

   task automatic test_extremes();
      bmpd_pkg::hdr_fields_type f;
      f = good_fields(MAX_DIM, MAX_DIM, 1'b1, 1'b1);
      build_header(f);
      send_file(f.data_offset + 9, 1'b1, 0);
      f = good_fields(MAX_DIM, MAX_DIM, 1'b0, 1'b0);
      build_header(f);
      send_file(f.data_offset + 6, 1'b0, 0);   // left open, the next file restarts
   endtask

   task automatic test_output_stall();
      bmpd_pkg::hdr_fields_type f;
      f = good_fields(8, 4, 1'b0, 1'b0);
      build_header(f);
      -> hold_start;
      send_file(image_len(f), 1'b1, 0);
   endtask

   task automatic test_random_files();
      bmpd_pkg::hdr_fields_type f;
      int unsigned              full, len, pick, ending, w, h;
      flaw_type                 fk;
      sent_bytes = 0;
      while (sent_bytes < RANDOM_BYTES) begin
         // a stretch with no idling on either side
         calm <= (sent_bytes >= 100 && sent_bytes < 400);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            w = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            h = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            f = good_fields(w, h, $urandom_range(0, 1), $urandom_range(0, 1));
            build_header(f);
            full   = image_len(f);
            ending = $urandom_range(0, 99);
            if (ending < 55) begin
               send_file(full, 1'b1, full);
            end else if (ending < 65) begin
               send_file(full + $urandom_range(1, 6), $urandom_range(0, 1), full);
            end else if (ending < 85) begin
               len = $urandom_range(bmpd_pkg::HDR_LAST + 1, full - 1);
               send_file(len, 1'b1, len);
            end else begin
               len = $urandom_range(1, full - 1);
               send_file(len, 1'b0, len);
            end
         end else if (pick < 90) begin
            fk = flaw_type'($urandom_range(0, fk.num() - 1));
            f  = flawed_fields(fk);
            build_header(f);
            send_file(bmpd_pkg::HDR_LAST + 1 + $urandom_range(0, 3), $urandom_range(0, 1),
                      bmpd_pkg::HDR_LAST + 1);
         end else begin
            // noise: random bytes from the first header byte on
            file_q.delete();
            len = $urandom_range(1, 70);
            send_file(len, $urandom_range(0, 1), len);
         end
      end
      calm <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_complete_images();
      test_header_rejects();
      test_early_end();
      test_restart();
      test_extremes();
      test_output_stall();
      test_random_files();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
